FILE: hdl/ie_pkg.sv
`default_nettype none

package ie_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 1'd1;

    // Register and result field widths.
    localparam int VALUE_COUNT_W    = 5;
    localparam int POSITION_COUNT_W = 4;
    localparam int POSITION_W       = 3;
    localparam int IMAGE_W          = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_SCAN,
        ST_RELEASE,
        ST_FOUND,
        ST_EMIT
    } ie_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_SINGLE,
        OP_LOAD,
        OP_SKIP,
        OP_TAKE,
        OP_BACK,
        OP_EXHAUST,
        OP_RELEASE,
        OP_FOUND,
        OP_EMIT
    } ie_op_t;

    typedef struct packed {
        ie_op_t op;
    } ie_cmd_t;

    typedef struct packed {
        logic finished;
        logic k_zero;
        logic depth_ge_k;
        logic depth_zero;
        logic cand_lt_n;
        logic cand_used;
        logic out_free;
        logic emit_last;
    } ie_status_t;

endpackage

`default_nettype wire

FILE: hdl/ie_ctrl.sv
`default_nettype none

module ie_ctrl
    import ie_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire ie_status_t status,
    output ie_cmd_t         cmd
);

    ie_state_t state_reg;
    ie_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.finished || status.k_zero) begin
                    if (status.out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (status.depth_ge_k) begin
                    state_next = ST_FOUND;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.cand_lt_n) begin
                    if (!status.cand_used) begin
                        state_next = ST_LOAD;
                    end
                end else if (status.depth_zero) begin
                    // Search space exhausted: report it through the single-word path.
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                state_next = ST_LOAD;
            end
            ST_FOUND: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.op  = OP_NONE;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_START;
                end
            end
            ST_DECIDE: begin
                if ((status.finished || status.k_zero) && status.out_free) begin
                    cmd.op = OP_SINGLE;
                end
            end
            ST_LOAD: begin
                cmd.op = status.depth_ge_k ? OP_FOUND : OP_LOAD;
            end
            ST_SCAN: begin
                if (status.cand_lt_n) begin
                    cmd.op = status.cand_used ? OP_SKIP : OP_TAKE;
                end else if (status.depth_zero) begin
                    cmd.op = OP_EXHAUST;
                end else begin
                    cmd.op = OP_BACK;
                end
            end
            ST_RELEASE: begin
                cmd.op = OP_RELEASE;
            end
            ST_FOUND: begin
                cmd.op = OP_RELEASE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op = OP_EMIT;
                end
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/ie_datapath.sv
`default_nettype none

module ie_datapath
    import ie_pkg::*;
#(
    parameter int MAX_VALUES    = 16,
    parameter int MAX_POSITIONS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_restart,
    input  wire logic                  m_ready,
    input  wire ie_cmd_t               cmd,
    output ie_status_t                 status,
    output logic                       m_valid,
    output logic                       m_produced,
    output logic [POSITION_W-1:0]      m_position,
    output logic [IMAGE_W-1:0]         m_image,
    output logic                       m_last
);

    localparam int NW = $clog2(MAX_VALUES + 1);
    localparam int VW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int DW = $clog2(MAX_POSITIONS + 1);
    localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

    logic [VALUE_COUNT_W-1:0]    vc_reg, vc_next;
    logic [POSITION_COUNT_W-1:0] pc_reg, pc_next;
    logic [VW-1:0]               chosen_reg [MAX_POSITIONS];
    logic [VW-1:0]               chosen_next [MAX_POSITIONS];
    logic [NW-1:0]               ncand_reg [MAX_POSITIONS];
    logic [NW-1:0]               ncand_next [MAX_POSITIONS];
    logic [MAX_VALUES-1:0]       in_use_reg, in_use_next;
    logic [DW-1:0]               depth_reg, depth_next;
    logic [NW-1:0]               cand_reg, cand_next;
    logic [PW-1:0]               oidx_reg, oidx_next;
    logic                        empty_reg, empty_next;
    logic                        fin_reg, fin_next;
    logic                        mvalid_reg, mvalid_next;
    logic                        produced_reg, produced_next;
    logic [POSITION_W-1:0]       position_reg, position_next;
    logic [IMAGE_W-1:0]          image_reg, image_next;
    logic                        last_reg, last_next;

    logic [NW-1:0]               en, en_new;
    logic [DW-1:0]               ek, ek_new;
    logic                        init;
    logic [PW-1:0]               d_idx, nd_idx, rd_idx;
    logic [DW-1:0]               nd;
    logic [VW-1:0]               c_idx, rd_val;
    logic [VW+IMAGE_W-1:0]       img_ext;
    logic [PW+POSITION_W-1:0]    pos_ext;
    logic                        emit_last;

    // Effective sizes clamp the registers to the storage that exists.
    assign en = (32'(vc_reg) > MAX_VALUES) ? NW'(MAX_VALUES) : NW'(vc_reg);
    assign ek = (32'(pc_reg) > MAX_POSITIONS) ? DW'(MAX_POSITIONS) : DW'(pc_reg);
    assign en_new = (32'(vc_next) > MAX_VALUES) ? NW'(MAX_VALUES) : NW'(vc_next);
    assign ek_new = (32'(pc_next) > MAX_POSITIONS) ? DW'(MAX_POSITIONS) : DW'(pc_next);

    assign init    = cfg_we || ((cmd.op == OP_START) && s_restart);
    assign d_idx   = depth_reg[PW-1:0];
    assign nd      = depth_reg + DW'(1);
    assign nd_idx  = nd[PW-1:0];
    assign c_idx   = cand_reg[VW-1:0];
    assign rd_idx  = (cmd.op == OP_EMIT) ? oidx_reg : d_idx;
    assign rd_val  = chosen_reg[rd_idx];
    assign img_ext = {{IMAGE_W{1'b0}}, rd_val};
    assign pos_ext = {{POSITION_W{1'b0}}, oidx_reg};
    assign emit_last = (DW'(oidx_reg) == (ek - DW'(1)));

    always_comb begin
        status.finished   = fin_reg;
        status.k_zero     = (ek == '0);
        status.depth_ge_k = (depth_reg >= ek);
        status.depth_zero = (depth_reg == '0);
        status.cand_lt_n  = (cand_reg < en);
        status.cand_used  = in_use_reg[c_idx];
        status.out_free   = !mvalid_reg || m_ready;
        status.emit_last  = emit_last;
    end

    always_comb begin
        vc_next       = vc_reg;
        pc_next       = pc_reg;
        chosen_next   = chosen_reg;
        ncand_next    = ncand_reg;
        in_use_next   = in_use_reg;
        depth_next    = depth_reg;
        cand_next     = cand_reg;
        oidx_next     = oidx_reg;
        empty_next    = empty_reg;
        fin_next      = fin_reg;
        mvalid_next   = mvalid_reg && !m_ready;
        produced_next = produced_reg;
        position_next = position_reg;
        image_next    = image_reg;
        last_next     = last_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_VALUE_COUNT: begin
                    vc_next = cfg_wdata[VALUE_COUNT_W-1:0];
                end
                REG_POSITION_COUNT: begin
                    pc_next = cfg_wdata[POSITION_COUNT_W-1:0];
                end
                default: begin
                    vc_next = vc_reg;
                end
            endcase
        end

        case (cmd.op)
            OP_SINGLE: begin
                // Either the exhausted marker or the one empty map for k = 0.
                mvalid_next   = 1'b1;
                produced_next = !fin_reg && !empty_reg;
                position_next = '0;
                image_next    = '0;
                last_next     = 1'b1;
                if (!fin_reg) begin
                    empty_next = 1'b1;
                end
            end
            OP_LOAD: begin
                cand_next = ncand_reg[d_idx];
            end
            OP_SKIP: begin
                cand_next = cand_reg + NW'(1);
            end
            OP_TAKE: begin
                chosen_next[d_idx] = c_idx;
                in_use_next[c_idx] = 1'b1;
                ncand_next[d_idx]  = cand_reg + NW'(1);
                depth_next         = nd;
                if (nd < ek) begin
                    ncand_next[nd_idx] = '0;
                end
            end
            OP_BACK: begin
                ncand_next[d_idx] = '0;
                depth_next        = depth_reg - DW'(1);
            end
            OP_EXHAUST: begin
                ncand_next[d_idx] = '0;
                fin_next          = 1'b1;
            end
            OP_RELEASE: begin
                in_use_next[rd_val] = 1'b0;
            end
            OP_FOUND: begin
                depth_next = ek - DW'(1);
                oidx_next  = '0;
            end
            OP_EMIT: begin
                mvalid_next   = 1'b1;
                produced_next = 1'b1;
                position_next = pos_ext[POSITION_W-1:0];
                image_next    = img_ext[IMAGE_W-1:0];
                last_next     = emit_last;
                oidx_next     = oidx_reg + PW'(1);
            end
            default: begin
                cand_next = cand_reg;
            end
        endcase

        if (init) begin
            for (int i = 0; i < MAX_POSITIONS; i++) begin
                ncand_next[i] = '0;
            end
            in_use_next = '0;
            depth_next  = '0;
            empty_next  = 1'b0;
            fin_next    = (32'(ek_new) > 32'(en_new));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg     <= '0;
            pc_reg     <= '0;
            for (int i = 0; i < MAX_POSITIONS; i++) begin
                ncand_reg[i] <= '0;
            end
            in_use_reg <= '0;
            depth_reg  <= '0;
            empty_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            vc_reg     <= vc_next;
            pc_reg     <= pc_next;
            ncand_reg  <= ncand_next;
            in_use_reg <= in_use_next;
            depth_reg  <= depth_next;
            empty_reg  <= empty_next;
            fin_reg    <= fin_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chosen_reg   <= chosen_next;
        cand_reg     <= cand_next;
        oidx_reg     <= oidx_next;
        produced_reg <= produced_next;
        position_reg <= position_next;
        image_reg    <= image_next;
        last_reg     <= last_next;
    end

    assign m_valid    = mvalid_reg;
    assign m_produced = produced_reg;
    assign m_position = position_reg;
    assign m_image    = image_reg;
    assign m_last     = last_reg;

endmodule

`default_nettype wire

FILE: hdl/injection_enumerator_top.sv
// Injection enumerator: each request word on the s_ channel returns the next
// injective map from k positions into n values, in lexicographic order.
// Set n (register 0, value_count) and k (register 1, position_count) through
// the cfg_ write port while the block is idle; every write restarts the
// enumeration. A request with s_restart high restarts it before searching.
// A found map leaves on the m_ channel as k words, one per position, with
// m_last on the final one. When no map is left or k exceeds n, the request
// gets one word with m_produced low and m_last high; k = 0 yields the empty
// map once. When the state is already finished, impossible or k = 0, the
// single word is loaded from the decide state that follows acceptance, once
// the output register is free. A map search runs through decide and load,
// then for each level descended a scan that takes a free value and a load;
// values already in use are skipped in the scan, and a level backed out
// passes through scan, release and load. A found state then closes the
// search and the emit state sends the output words. One request is worked
// on at a time; the next is taken from the cycle after its last word is
// loaded into the output register. While the receiver holds m_ready low, the
// block waits before loading the next word until the output register frees.
// Reset clears both registers to zero (n = k = 0) and the search state, and
// drops m_valid.
`default_nettype none

module injection_enumerator_top
    import ie_pkg::*;
#(
    parameter int MAX_VALUES    = 16,
    parameter int MAX_POSITIONS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_restart,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_produced,
    output logic [POSITION_W-1:0]      m_position,
    output logic [IMAGE_W-1:0]         m_image,
    output logic                       m_last
);

    ie_cmd_t    cmd;
    ie_status_t status;

    ie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ie_datapath #(
        .MAX_VALUES    (MAX_VALUES),
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_restart  (s_restart),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .status     (status),
        .m_valid    (m_valid),
        .m_produced (m_produced),
        .m_position (m_position),
        .m_image    (m_image),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

FILE: hdl/ie_checker.sv
`default_nettype none

module ie_checker
    import ie_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_produced,
    input wire logic [POSITION_W-1:0] m_position,
    input wire logic [IMAGE_W-1:0]    m_image,
    input wire logic                  m_last
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_produced) && $stable(m_position)
            && $stable(m_image) && $stable(m_last))
        else $error("stalled result word changed");

    // A word without a map is always the only word of its request.
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_produced |-> m_last && (m_position == '0) && (m_image == '0))
        else $error("malformed no-map word");

    // One request at a time: no new request right after one is taken.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one is in progress");

endmodule

bind injection_enumerator_top ie_checker u_ie_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_produced (m_produced),
    .m_position (m_position),
    .m_image    (m_image),
    .m_last     (m_last)
);

`default_nettype wire
